FILE: sv/ahp_pkg.sv
package ahp_pkg;

   // Four-character tags, big-endian as they appear in the file
   localparam logic [31:0] TAG_FORM = 32'h464F_524D;
   localparam logic [31:0] TAG_AIFF = 32'h4149_4646;
   localparam logic [31:0] TAG_AIFC = 32'h4149_4643;
   localparam logic [31:0] TAG_COMM = 32'h434F_4D4D;
   localparam logic [31:0] TAG_NONE = 32'h4E4F_4E45;
   localparam logic [31:0] TAG_SOWT = 32'h736F_7774;

   // COMM body offsets (relative to the size field), last byte of each field
   localparam logic [4:0] COMM_POS_CHANNELS = 5'd5;
   localparam logic [4:0] COMM_POS_FRAMES   = 5'd9;
   localparam logic [4:0] COMM_POS_BITS     = 5'd11;
   localparam logic [4:0] COMM_POS_LAST     = 5'd21;
   localparam logic [4:0] WORD_POS_LAST     = 5'd3;

   localparam int RSP_DATA_W = 72;

   typedef enum logic [8:0] {
      PH_FORM   = 9'b000000001,
      PH_FSIZE  = 9'b000000010,
      PH_FTYPE  = 9'b000000100,
      PH_CKID   = 9'b000001000,
      PH_CKSIZE = 9'b000010000,
      PH_SKIP   = 9'b000100000,
      PH_COMM   = 9'b001000000,
      PH_COMP   = 9'b010000000,
      PH_DONE   = 9'b100000000
   } phase_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_NO_FORM   = 3'd1,
      STATUS_BAD_TYPE  = 3'd2,
      STATUS_BAD_COMP  = 3'd3,
      STATUS_TRUNCATED = 3'd4
   } status_type;

   // Packed so that header_ok lands in bit 0
   typedef struct packed {
      logic [15:0] sample_bits;
      logic [31:0] sample_frames;
      logic [15:0] channel_count;
      logic        is_compressed_form;
      status_type  status;
      logic        header_ok;
   } result_type;

endpackage

FILE: sv/ahp_parser.sv
module ahp_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_accept,
   input  logic [7:0]          data_byte,
   input  logic                end_of_file,
   output logic                result_valid,
   output ahp_pkg::result_type result,
   input  logic                result_ready
);
   import ahp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] skip_ff, skip_in;
   logic        aifc_ff, aifc_in;
   logic [15:0] channels_ff, channels_in;
   logic [31:0] frames_ff, frames_in;
   logic [15:0] bits_ff, bits_in;
   logic        given_ff, given_in;

   logic [31:0] shift_new;
   logic        word_last;
   logic        emit;
   logic        emit_ok;
   status_type  emit_status;

   assign shift_new = {shift_ff[23:0], data_byte};
   assign word_last = (pos_ff >= WORD_POS_LAST);

   // Phase and field tracking for one byte
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      shift_in    = shift_ff;
      skip_in     = skip_ff;
      aifc_in     = aifc_ff;
      channels_in = channels_ff;
      frames_in   = frames_ff;
      bits_in     = bits_ff;
      given_in    = given_ff;
      emit        = 1'b0;
      emit_ok     = 1'b0;
      emit_status = STATUS_OK;

      if (!given_ff) begin
         shift_in = shift_new;
         case (phase_ff)
            PH_FORM: begin
               pos_in = word_last ? 5'd0 : pos_ff + 5'd1;
               if (word_last) begin
                  if (shift_new != TAG_FORM) begin
                     emit        = 1'b1;
                     emit_status = STATUS_NO_FORM;
                  end else begin
                     phase_in = PH_FSIZE;
                  end
               end
            end
            PH_FSIZE: begin
               pos_in = word_last ? 5'd0 : pos_ff + 5'd1;
               if (word_last) phase_in = PH_FTYPE;
            end
            PH_FTYPE: begin
               pos_in = word_last ? 5'd0 : pos_ff + 5'd1;
               if (word_last) begin
                  if (shift_new == TAG_AIFF) begin
                     aifc_in  = 1'b0;
                     phase_in = PH_CKID;
                  end else if (shift_new == TAG_AIFC) begin
                     aifc_in  = 1'b1;
                     phase_in = PH_CKID;
                  end else begin
                     emit        = 1'b1;
                     emit_status = STATUS_BAD_TYPE;
                  end
               end
            end
            PH_CKID: begin
               pos_in = word_last ? 5'd0 : pos_ff + 5'd1;
               if (word_last) phase_in = (shift_new == TAG_COMM) ? PH_COMM : PH_CKSIZE;
            end
            PH_CKSIZE: begin
               pos_in = word_last ? 5'd0 : pos_ff + 5'd1;
               if (word_last) begin
                  skip_in  = shift_new;
                  phase_in = (shift_new != 32'd0) ? PH_SKIP : PH_CKID;
               end
            end
            PH_SKIP: begin
               // size was consumed with position at zero; no pad byte is skipped after an odd body
               skip_in = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  phase_in = PH_CKID;
                  pos_in   = 5'd0;
               end
            end
            PH_COMM: begin
               if (pos_ff == COMM_POS_CHANNELS) channels_in = shift_new[15:0];
               else if (pos_ff == COMM_POS_FRAMES) frames_in = shift_new;
               else if (pos_ff == COMM_POS_BITS) bits_in = shift_new[15:0];
               if (pos_ff >= COMM_POS_LAST) begin
                  pos_in = 5'd0;
                  if (aifc_ff) begin
                     phase_in = PH_COMP;
                  end else begin
                     emit    = 1'b1;
                     emit_ok = 1'b1;
                  end
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
            PH_COMP: begin
               pos_in = word_last ? 5'd0 : pos_ff + 5'd1;
               if (word_last) begin
                  emit = 1'b1;
                  if (shift_new == TAG_NONE || shift_new == TAG_SOWT) begin
                     emit_ok = 1'b1;
                  end else begin
                     emit_status = STATUS_BAD_COMP;
                  end
               end
            end
            default: begin
            end
         endcase

         // File ended before a decision
         if (end_of_file && !emit) begin
            emit        = 1'b1;
            emit_status = STATUS_TRUNCATED;
         end
         if (emit) begin
            given_in = 1'b1;
            phase_in = PH_DONE;
         end
      end
   end

   // Result payload
   always_comb begin
      result.header_ok          = emit_ok;
      result.status             = emit_status;
      result.is_compressed_form = aifc_in;
      result.channel_count      = emit_ok ? channels_in : 16'd0;
      result.sample_frames      = emit_ok ? frames_in : 32'd0;
      result.sample_bits        = emit_ok ? bits_in : 16'd0;
   end

   assign result_valid = byte_accept && emit;

   // State registers, cleared by reset and at end of each file
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FORM;
         pos_ff      <= 5'd0;
         shift_ff    <= 32'd0;
         skip_ff     <= 32'd0;
         aifc_ff     <= 1'b0;
         channels_ff <= 16'd0;
         frames_ff   <= 32'd0;
         bits_ff     <= 16'd0;
         given_ff    <= 1'b0;
      end else if (byte_accept) begin
         if (end_of_file) begin
            phase_ff    <= PH_FORM;
            pos_ff      <= 5'd0;
            shift_ff    <= 32'd0;
            skip_ff     <= 32'd0;
            aifc_ff     <= 1'b0;
            channels_ff <= 16'd0;
            frames_ff   <= 32'd0;
            bits_ff     <= 16'd0;
            given_ff    <= 1'b0;
         end else begin
            phase_ff    <= phase_in;
            pos_ff      <= pos_in;
            shift_ff    <= shift_in;
            skip_ff     <= skip_in;
            aifc_ff     <= aifc_in;
            channels_ff <= channels_in;
            frames_ff   <= frames_in;
            bits_ff     <= bits_in;
            given_ff    <= given_in;
         end
      end
   end

   // Checks
   a_result_taken: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> result_ready)
      else $error("result produced while output stage cannot take it");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      result_valid && result.header_ok |-> result.status == STATUS_OK)
      else $error("accepted header with nonzero status");

   a_done_given: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) == given_ff)
      else $error("done phase and result flag disagree");

   a_eof_clear: assert property (@(posedge clock) disable iff (reset)
      byte_accept && end_of_file |=> phase_ff == PH_FORM && !given_ff && pos_ff == 5'd0)
      else $error("parser not cleared after end of file");

endmodule

FILE: sv/ahp_out_skid.sv
module ahp_out_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  ahp_pkg::result_type in_data,
   output logic                in_ready,
   output logic                out_valid,
   output ahp_pkg::result_type out_data,
   input  logic                out_ready
);
   import ahp_pkg::*;

   logic       main_valid_ff, main_valid_in;
   result_type main_ff, main_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_ff, skid_in;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Main register drains first; skid catches a result while main is stalled
   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_in       = in_data;
         end
      end else if (in_valid && in_ready) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // Checks
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds a result while main register is empty");

   a_skid_to_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> main_valid_ff && main_ff == $past(skid_ff))
      else $error("skid result not moved to main register");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      main_valid_ff && !out_ready |=> main_valid_ff && $stable(main_ff))
      else $error("stalled result changed");

endmodule

FILE: sv/aiff_header_parser_top.sv
// AIFF/AIFC header parser. Feed the file one byte per transaction on the
// req_ stream, with req_tlast on the final byte; the block accepts one byte
// every cycle while req_tready is high, and a byte is fully handled in the
// cycle it is accepted (one pass through the phase logic into the result
// register). It checks FORM, the AIFF/AIFC form type, skips chunks by size up
// to COMM, captures channel count, sample frames and bits per sample, and for
// AIFC checks the NONE/sowt compression tag. Exactly one result transaction
// per file appears on the rsp_ stream, registered from the deciding byte (or
// the last byte, status truncated) and held while rsp_tready is low. Bytes
// after the decision are ignored until req_tlast, after which the parser is
// ready for the next file. A two-entry output buffer keeps req_tready high
// while a result waits; it drops only when two results are pending.
module aiff_header_parser_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [7:0] data_byte
   input  logic                           req_tlast,  // end_of_file
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] header_ok, [3:1] status, [4] is_compressed_form, [20:5] channel_count,
   // [52:21] sample_frames, [68:53] sample_bits, [71:69] zero
   output logic [ahp_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import ahp_pkg::*;

   logic       byte_accept;
   logic       result_valid;
   logic       result_ready;
   result_type result;
   result_type rsp_result;

   assign byte_accept = req_tvalid && req_tready;
   assign req_tready  = result_ready;

   ahp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .data_byte    (req_tdata),
      .end_of_file  (req_tlast),
      .result_valid (result_valid),
      .result       (result),
      .result_ready (result_ready)
   );

   ahp_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (result_valid),
      .in_data   (result),
      .in_ready  (result_ready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_result),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {(RSP_DATA_W - $bits(result_type))'(0), rsp_result};

endmodule

FILE: tb/tb_aiff_header_parser_top.sv
module tb_aiff_header_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ahp_pkg::*;

   localparam int STREAM_BYTES   = 1800;
   localparam int CALM_TAIL      = 300;
   localparam int WATCHDOG_LIMIT = 400;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] data_byte
   logic                  req_tlast;   // end_of_file
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // [0] header_ok, [3:1] status, [4] is_compressed_form, [20:5] channel_count,
   // [52:21] sample_frames, [68:53] sample_bits, [71:69] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;

   aiff_header_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // One file byte on the request stream
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } file_byte_type;

   // Directed row; a pinned row carries its reject verdict typed in
   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       pin;
      logic       ok;
      status_type code;
      logic       aifc;
   } directed_byte_type;

   directed_byte_type directed_rows[$] = '{
      // one-byte file: ends before any decision
      '{8'h00, 1'b1, 1'b1, 1'b0, STATUS_TRUNCATED, 1'b0},
      // "FOR" + 0xFF: no FORM on the fourth byte, then one ignored byte ends it
      '{8'h46, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h4F, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h52, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'hFF, 1'b0, 1'b1, 1'b0, STATUS_NO_FORM,   1'b0},
      '{8'hFF, 1'b1, 1'b0, 1'b0, STATUS_OK,        1'b0},
      // "FORM" with end of file on its last byte
      '{8'h46, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h4F, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h52, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h4D, 1'b1, 1'b1, 1'b0, STATUS_TRUNCATED, 1'b0},
      // "FORM", size at byte extremes, "AIFX": bad type decided on the final byte
      '{8'h46, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h4F, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h52, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h4D, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h41, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h49, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h46, 1'b0, 1'b0, 1'b0, STATUS_OK,        1'b0},
      '{8'h58, 1'b1, 1'b1, 1'b0, STATUS_BAD_TYPE,  1'b0}
   };

   result_type    verdicts_due[$];
   file_byte_type file_bytes[$];

   int   mismatches   = 0;
   int   quiet_cycles = 0;
   logic no_idle      = 1'b0;
   logic src_bursty   = 1'b1;
   logic sink_bursty  = 1'b1;

   // Sideband that travels with each byte: a typed verdict for pinned rows
   logic       pin_on;
   result_type pin_val;

   // Header parser state as the block holds it
   phase_type   hdr_phase;
   logic [4:0]  hdr_pos;
   logic [31:0] hdr_shift;
   logic [31:0] hdr_skip;
   logic        hdr_aifc;
   logic [15:0] hdr_chan;
   logic [31:0] hdr_frames;
   logic [15:0] hdr_bits;
   logic        hdr_decided;

   // Clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_parser();
      hdr_phase   = PH_FORM;
      hdr_pos     = '0;
      hdr_shift   = '0;
      hdr_skip    = '0;
      hdr_aifc    = 1'b0;
      hdr_chan    = '0;
      hdr_frames  = '0;
      hdr_bits    = '0;
      hdr_decided = 1'b0;
   endfunction

   // Counts through a 4-byte field; true on its last byte
   function automatic logic word_end();
      if (hdr_pos >= WORD_POS_LAST) begin
         hdr_pos = '0;
         return 1'b1;
      end
      hdr_pos = hdr_pos + 5'd1;
      return 1'b0;
   endfunction

   function automatic result_type verdict(input logic ok, input status_type code);
      result_type v;
      v = '0;
      v.header_ok          = ok;
      v.status             = code;
      v.is_compressed_form = hdr_aifc;
      if (ok) begin
         v.channel_count = hdr_chan;
         v.sample_frames = hdr_frames;
         v.sample_bits   = hdr_bits;
      end
      hdr_decided = 1'b1;
      hdr_phase   = PH_DONE;
      return v;
   endfunction

   // Advances the header parse by one byte; fired marks a verdict on this byte
   task automatic parse_byte(input logic [7:0] b, input logic last,
                             output logic fired, output result_type v);
      fired = 1'b0;
      v     = '0;
      if (!hdr_decided) begin
         hdr_shift = {hdr_shift[23:0], b};
         case (hdr_phase)
            PH_FORM: begin
               if (word_end()) begin
                  if (hdr_shift != TAG_FORM) begin
                     v     = verdict(1'b0, STATUS_NO_FORM);
                     fired = 1'b1;
                  end else begin
                     hdr_phase = PH_FSIZE;
                  end
               end
            end
            PH_FSIZE: begin
               if (word_end()) hdr_phase = PH_FTYPE;
            end
            PH_FTYPE: begin
               if (word_end()) begin
                  if (hdr_shift == TAG_AIFF) begin
                     hdr_aifc  = 1'b0;
                     hdr_phase = PH_CKID;
                  end else if (hdr_shift == TAG_AIFC) begin
                     hdr_aifc  = 1'b1;
                     hdr_phase = PH_CKID;
                  end else begin
                     v     = verdict(1'b0, STATUS_BAD_TYPE);
                     fired = 1'b1;
                  end
               end
            end
            PH_CKID: begin
               if (word_end()) hdr_phase = (hdr_shift == TAG_COMM) ? PH_COMM : PH_CKSIZE;
            end
            PH_CKSIZE: begin
               if (word_end()) begin
                  hdr_skip  = hdr_shift;
                  hdr_phase = (hdr_skip != 0) ? PH_SKIP : PH_CKID;
               end
            end
            // No pad byte is dropped after an odd body: it is read as chunk id
            PH_SKIP: begin
               hdr_skip = hdr_skip - 32'd1;
               if (hdr_skip == 0) begin
                  hdr_phase = PH_CKID;
                  hdr_pos   = '0;
               end
            end
            PH_COMM: begin
               if (hdr_pos == COMM_POS_CHANNELS) hdr_chan = hdr_shift[15:0];
               else if (hdr_pos == COMM_POS_FRAMES) hdr_frames = hdr_shift;
               else if (hdr_pos == COMM_POS_BITS) hdr_bits = hdr_shift[15:0];
               if (hdr_pos >= COMM_POS_LAST) begin
                  hdr_pos = '0;
                  if (hdr_aifc) begin
                     hdr_phase = PH_COMP;
                  end else begin
                     v     = verdict(1'b1, STATUS_OK);
                     fired = 1'b1;
                  end
               end else begin
                  hdr_pos = hdr_pos + 5'd1;
               end
            end
            PH_COMP: begin
               if (word_end()) begin
                  if (hdr_shift == TAG_NONE || hdr_shift == TAG_SOWT)
                     v = verdict(1'b1, STATUS_OK);
                  else
                     v = verdict(1'b0, STATUS_BAD_COMP);
                  fired = 1'b1;
               end
            end
            default: ;
         endcase
      end
      // End of file: truncated unless already decided, then start over
      if (last) begin
         if (!hdr_decided) begin
            v     = verdict(1'b0, STATUS_TRUNCATED);
            fired = 1'b1;
         end
         clear_parser();
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic put_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) file_bytes.push_back('{data: w[8*i +: 8], last: 1'b0});
   endtask

   task automatic put_random(input int n);
      repeat (n) file_bytes.push_back('{data: 8'($urandom), last: 1'b0});
   endtask

   // One file: mostly well-formed headers with random content, some cut short,
   // corrupted or plain noise
   task automatic build_file();
      int          shape;
      int          nchunks;
      int          size;
      logic        huge;
      logic [31:0] form_tag;
      logic [31:0] comp_tag;
      file_bytes.delete();
      shape = $urandom_range(0, 9);
      huge  = 1'b0;
      if (shape == 0) begin
         put_random($urandom_range(1, 12));
      end else begin
         put_word(TAG_FORM);
         put_random(4);
         form_tag = $urandom_range(0, 1) ? TAG_AIFC : TAG_AIFF;
         put_word(form_tag);
         nchunks = $urandom_range(0, 3);
         for (int c = 0; c < nchunks && !huge; c++) begin
            put_word($urandom);
            if ($urandom_range(0, 7) == 0) begin
               // huge size: the file ends long before the body does
               put_word($urandom | 32'h0100_0000);
               put_random($urandom_range(0, 6));
               huge = 1'b1;
            end else begin
               size = $urandom_range(0, 9);
               put_word(size);
               put_random(size);
               if (size % 2 == 1 && $urandom_range(0, 1) == 1) put_random(1);
            end
         end
         if (!huge) begin
            put_word(TAG_COMM);
            put_word($urandom_range(18, 30));
            put_random(18);
            if (form_tag == TAG_AIFC) begin
               case ($urandom_range(0, 4))
                  0:       comp_tag = $urandom;
                  1, 2:    comp_tag = TAG_NONE;
                  default: comp_tag = TAG_SOWT;
               endcase
               put_word(comp_tag);
            end
            put_random($urandom_range(0, 6));
         end
      end
      if (shape == 1 || shape == 2) begin
         size = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > size) void'(file_bytes.pop_back());
      end else if (shape == 3) begin
         size = $urandom_range(0, file_bytes.size() - 1);
         file_bytes[size].data = file_bytes[size].data ^ 8'(1 << $urandom_range(0, 7));
      end
      file_bytes[file_bytes.size() - 1].last = 1'b1;
   endtask

   // Presents one byte at the falling edge, returns at the falling edge after
   // the transaction
   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic pin, input result_type pinned);
      if (!no_idle && src_bursty && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      pin_on     <= pin;
      pin_val    <= pinned;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Stimulus
   initial begin : stimulus
      int         sent;
      result_type pinned;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      pin_on     = 1'b0;
      pin_val    = '0;
      clear_parser();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         pinned                    = '0;
         pinned.header_ok          = directed_rows[i].ok;
         pinned.status             = directed_rows[i].code;
         pinned.is_compressed_form = directed_rows[i].aifc;
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].pin, pinned);
      end
      sent = directed_rows.size();

      while (sent < STREAM_BYTES) begin
         build_file();
         src_bursty = ($urandom_range(0, 2) != 0);
         no_idle    = (sent > STREAM_BYTES - CALM_TAIL);
         foreach (file_bytes[i]) send_byte(file_bytes[i].data, file_bytes[i].last, 1'b0, '0);
         sent += file_bytes.size();
      end
      req_tvalid <= 1'b0;

      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Result side: random stall bursts, none in the final stretch
   initial begin : result_sink
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) sink_bursty = !sink_bursty;
         if (!no_idle && sink_bursty && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Compare results against predictions, then predict from this edge's byte
   always @(posedge clock) begin : scoreboard
      logic       fired;
      result_type predicted;
      result_type want;
      result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[68:0];
            if (verdicts_due.size() == 0) begin
               $error("result transaction with none outstanding: %0h", rsp_tdata);
               mismatches++;
            end else begin
               want = verdicts_due.pop_front();
               check_field("header_ok", 32'(want.header_ok), 32'(got.header_ok));
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("is_compressed_form", 32'(want.is_compressed_form),
                           32'(got.is_compressed_form));
               check_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
               check_field("sample_frames", want.sample_frames, got.sample_frames);
               check_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
               check_field("zero_fill", 32'd0, 32'(rsp_tdata[RSP_DATA_W-1:69]));
            end
         end
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tlast, fired, predicted);
            if (fired) verdicts_due.push_back(pin_on ? pin_val : predicted);
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Watchdog on cycles with no transaction on either side
   initial begin : watchdog
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
sv/ahp_pkg.sv
sv/ahp_parser.sv
sv/ahp_out_skid.sv
sv/aiff_header_parser_top.sv
tb/tb_aiff_header_parser_top.sv
